FILE: hdl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared constants and helpers for the sieve prime search block
// Word geometry of the sieve bit store and bit-position encoders.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // highest set bit of a word (0 when empty)
  function automatic logic [BIT_W-1:0] msb_index(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // lowest set bit of a word (0 when empty)
  function automatic logic [BIT_W-1:0] lsb_index(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: hdl/sps_bitram.sv
// ----------------------------------------------------------------------------
// sps_bitram: sieve bit store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sps_bitram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sps_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [sps_pkg::WORD_W-1:0] rdata
);
  import sps_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/sieve_prime_search_top.sv
// ----------------------------------------------------------------------------
// sieve_prime_search_top: prime lookup over a sieved bit table
// Sieves a bit store after reset, then answers nearest-prime queries.
// ----------------------------------------------------------------------------
//
//  channel | ports                        | dir | role
//  --------+------------------------------+-----+-------------------------------
//  in      | in_valid in_ready            | in  | query: in_mode, in_value
//          |  in_mode in_value            |     |  (0 = prime <= value, 1 = >=)
//  out     | out_valid out_ready          | out | result: out_prime, out_found
//          |  out_prime out_found         |     |
//
//  Reset: the store is filled (one word of 32 bits a cycle, ceil(N/32) words,
//  N = min(TABLE_SIZE, 65536)) and then sieved with one read and one write
//  per cleared multiple and one read per candidate prime. in_ready stays low
//  until the sieve is done. A query reads the start word and then further
//  words in turn through the single memory read port until a prime turns up
//  or the table end in its direction is reached; an out-of-range query goes
//  straight to the done state as a miss. A stalled result waits in the output
//  register; the next transaction is taken meanwhile and held in the done
//  state until the output register frees.
// ----------------------------------------------------------------------------
module sieve_prime_search_top #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_prime,
  output logic        out_found
);
  import sps_pkg::*;

  // only numbers below 65536 can ever be reported, so the store stops there
  localparam int EFF       = (TABLE_SIZE > 65536) ? 65536 : TABLE_SIZE;
  localparam int DEPTH     = (EFF + WORD_W - 1) / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW        = AW + BIT_W + 1;   // holds m + p without wrap
  localparam int LAST_CNT  = EFF - WORD_W * (DEPTH - 1);
  localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_CNT);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [MW-1:0]     EFF_M     = MW'(EFF);
  localparam logic [16:0]       EFF_Q     = 17'(EFF);

  typedef enum logic [8:0] {
    ST_FILL  = 9'b000000001,
    ST_SVP   = 9'b000000010,  // test loop bound, read word of p
    ST_SVCHK = 9'b000000100,  // p prime?
    ST_SVRD  = 9'b000001000,  // read word of multiple m
    ST_SVWR  = 9'b000010000,  // clear bit of m
    ST_IDLE  = 9'b000100000,
    ST_QSCAN = 9'b001000000,  // one word per cycle
    ST_QDONE = 9'b010000000,
    ST_SPARE = 9'b100000000   // unused code, falls back to idle
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     fill_addr_r, fill_addr_nxt;
  logic [MW-1:0]     p_r, p_nxt;
  logic [MW-1:0]     sq_r, sq_nxt;
  logic [MW-1:0]     m_r, m_nxt;
  logic              sieve_done_r, sieve_done_nxt;
  logic              q_mode_r, q_mode_nxt;
  logic [AW-1:0]     q_addr_r, q_addr_nxt;
  logic [BIT_W-1:0]  q_bit_r, q_bit_nxt;
  logic [15:0]       res_prime_r, res_prime_nxt;
  logic              res_found_r, res_found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_prime_r, out_prime_nxt;
  logic              out_found_r, out_found_nxt;

  // memory port
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  // scan helpers
  logic [WORD_W-1:0] fill_word;
  logic [WORD_W-1:0] scan_mask;
  logic              scan_hit;
  logic [BIT_W-1:0]  scan_pos;
  logic [15:0]       in_start;
  logic              in_ok;
  logic              in_take;
  logic              out_free;

  sps_bitram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_bitram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // 0 and 1 are not prime; bits past the table end are never set
  always_comb begin
    fill_word = {WORD_W{1'b1}};
    if (fill_addr_r == '0)      fill_word = fill_word & ~WORD_W'(3);
    if (fill_addr_r == LAST_ADDR) fill_word = fill_word & LAST_MASK;
  end

  // mode 1 starts at two at least; mode 0 needs 2 <= value < N
  assign in_start = (in_mode && in_value < 16'd2) ? 16'd2 : in_value;
  assign in_ok    = in_mode ? ({1'b0, in_start} < EFF_Q)
                            : (in_value >= 16'd2 && {1'b0, in_value} < EFF_Q);

  assign in_ready = (state_r == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // mode 0 keeps bits at or below the start, mode 1 at or above
  assign scan_mask = q_mode_r ? (mem_rdata & ({WORD_W{1'b1}} << q_bit_r))
                              : (mem_rdata & ({WORD_W{1'b1}} >> (5'd31 - q_bit_r)));
  assign scan_hit  = |scan_mask;
  assign scan_pos  = q_mode_r ? lsb_index(scan_mask) : msb_index(scan_mask);

  always_comb begin
    state_nxt      = state_r;
    fill_addr_nxt  = fill_addr_r;
    p_nxt          = p_r;
    sq_nxt         = sq_r;
    m_nxt          = m_r;
    sieve_done_nxt = sieve_done_r;
    q_mode_nxt     = q_mode_r;
    q_addr_nxt     = q_addr_r;
    q_bit_nxt      = q_bit_r;
    res_prime_nxt  = res_prime_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_prime_nxt  = out_prime_r;
    out_found_nxt  = out_found_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_addr_r;
    mem_wdata      = fill_word;
    mem_re         = 1'b0;
    mem_raddr      = p_r[AW+BIT_W-1:BIT_W];

    case (state_r)
      ST_FILL: begin
        mem_we        = 1'b1;
        fill_addr_nxt = fill_addr_r + AW'(1);
        if (fill_addr_r == LAST_ADDR) begin
          p_nxt     = MW'(2);
          sq_nxt    = MW'(4);
          state_nxt = ST_SVP;
        end
      end
      ST_SVP: begin
        if (sq_r >= EFF_M) begin
          sieve_done_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_SVCHK;
        end
      end
      ST_SVCHK: begin
        if (mem_rdata[p_r[BIT_W-1:0]]) begin
          m_nxt     = sq_r;
          state_nxt = ST_SVRD;
        end else begin
          // (p+1)^2 = p^2 + 2p + 1
          p_nxt     = p_r + MW'(1);
          sq_nxt    = sq_r + {p_r[MW-2:0], 1'b1};
          state_nxt = ST_SVP;
        end
      end
      ST_SVRD: begin
        mem_raddr = m_r[AW+BIT_W-1:BIT_W];
        if (m_r >= EFF_M) begin
          p_nxt     = p_r + MW'(1);
          sq_nxt    = sq_r + {p_r[MW-2:0], 1'b1};
          state_nxt = ST_SVP;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_SVWR;
        end
      end
      ST_SVWR: begin
        mem_we    = 1'b1;
        mem_waddr = m_r[AW+BIT_W-1:BIT_W];
        mem_wdata = mem_rdata & ~(WORD_W'(1) << m_r[BIT_W-1:0]);
        m_nxt     = m_r + p_r;
        state_nxt = ST_SVRD;
      end
      ST_IDLE: begin
        mem_raddr = in_start[AW+BIT_W-1:BIT_W];
        if (in_take) begin
          q_mode_nxt = in_mode;
          q_addr_nxt = in_start[AW+BIT_W-1:BIT_W];
          q_bit_nxt  = in_start[BIT_W-1:0];
          if (in_ok) begin
            mem_re    = 1'b1;
            state_nxt = ST_QSCAN;
          end else begin
            res_prime_nxt = '0;
            res_found_nxt = 1'b0;
            state_nxt     = ST_QDONE;
          end
        end
      end
      ST_QSCAN: begin
        if (scan_hit) begin
          res_prime_nxt = 16'({q_addr_r, scan_pos});
          res_found_nxt = 1'b1;
          state_nxt     = ST_QDONE;
        end else if (( q_mode_r && q_addr_r == LAST_ADDR) ||
                     (!q_mode_r && q_addr_r == '0)) begin
          res_prime_nxt = '0;
          res_found_nxt = 1'b0;
          state_nxt     = ST_QDONE;
        end else begin
          q_addr_nxt = q_mode_r ? q_addr_r + AW'(1) : q_addr_r - AW'(1);
          q_bit_nxt  = q_mode_r ? '0 : BIT_W'(WORD_W - 1);
          mem_raddr  = q_addr_nxt;
          mem_re     = 1'b1;
        end
      end
      ST_QDONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_prime_r;
          out_found_nxt = res_found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      fill_addr_r  <= '0;
      sieve_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_addr_r  <= fill_addr_nxt;
      sieve_done_r <= sieve_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    sq_r        <= sq_nxt;
    m_r         <= m_nxt;
    q_mode_r    <= q_mode_nxt;
    q_addr_r    <= q_addr_nxt;
    q_bit_r     <= q_bit_nxt;
    res_prime_r <= res_prime_nxt;
    res_found_r <= res_found_nxt;
    out_prime_r <= out_prime_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_prime = out_prime_r;
  assign out_found = out_found_r;

`ifndef ASSERT_OFF
  // no query transaction before the sieve has finished
  a_no_query_during_sieve: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> sieve_done_r)
    else $error("query accepted before sieve done");

  // the store is only written by the fill and the sieve
  a_write_only_in_sieve: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FILL || state_r == ST_SVWR))
    else $error("bit store written outside sieve");

  // a new result only comes out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && !out_ready)) |-> $past(state_r == ST_QDONE))
    else $error("result loaded outside done state");

  // a miss always reports prime zero
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_prime == 16'd0))
    else $error("miss with nonzero prime");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sieve prime search block
// Waits out the sieve after reset, sends directed and random queries in both
// modes and predicts the answers not typed in from a local prime table. Both
// handshakes idle at random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_SIZE   = 65536;
  // highest value the block can report: table end or output width, whichever
  // is lower
  localparam int SEARCH_TOP   = (TABLE_SIZE - 1 < 65535) ? TABLE_SIZE - 1 : 65535;
  localparam int RANDOM_ITEMS = 1825;
  localparam int IDLE_PCT     = 27;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 24;
  // the block accepts nothing while the sieve runs after reset
  localparam int STALL_LIMIT  = 1200000;

  typedef enum logic {
    MODE_AT_OR_BELOW = 1'b0,
    MODE_AT_OR_ABOVE = 1'b1
  } search_mode_t;

  // one row of the directed table; typed rows carry their answer
  typedef struct packed {
    search_mode_t mode;
    logic [15:0]  value;
    logic         typed;
    logic [15:0]  prime;
    logic         found;
  } query_row_t;

  // expected answer, with its query kept for messages
  typedef struct packed {
    search_mode_t mode;
    logic [15:0]  value;
    logic [15:0]  prime;
    logic         found;
  } answer_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_mode   = 1'b0;
  logic [15:0] in_value  = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] out_prime;
  logic        out_found;

  bit          is_prime [0:TABLE_SIZE-1];
  query_row_t  query_table[$];
  answer_t     awaited_primes[$];
  answer_t     head;

  int offered      = 0;
  int directed_cnt = 0;
  int checked      = 0;
  int not_found    = 0;
  int errors       = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  always #4 clk = ~clk;

  sieve_prime_search_top #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_value (in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_prime(out_prime),
    .out_found(out_found)
  );

  // A stretch of transactions with no idling on either side.
  function automatic bit calm_stretch();
    return offered >= 600 && offered < 900;
  endfunction

  // Nearest prime in the requested direction, from the local table.
  function automatic answer_t nearest_prime(input search_mode_t mode,
                                            input logic [15:0] value);
    answer_t a;
    int      n;
    a.mode  = mode;
    a.value = value;
    a.prime = '0;
    a.found = 1'b0;
    if (mode == MODE_AT_OR_BELOW) begin
      // values past the table end could have their answer outside it
      if (value >= 2 && int'(value) < TABLE_SIZE) begin
        for (n = int'(value); n >= 2; n--) begin
          if (is_prime[n]) begin
            a.prime = 16'(n);
            a.found = 1'b1;
            break;
          end
        end
      end
    end else begin
      for (n = (value < 2) ? 2 : int'(value); n <= SEARCH_TOP; n++) begin
        if (is_prime[n]) begin
          a.prime = 16'(n);
          a.found = 1'b1;
          break;
        end
      end
    end
    return a;
  endfunction

  task automatic add_row(input search_mode_t mode, input logic [15:0] value,
                         input logic typed, input logic [15:0] prime,
                         input logic found);
    query_row_t r;
    r.mode  = mode;
    r.value = value;
    r.typed = typed;
    r.prime = prime;
    r.found = found;
    query_table.push_back(r);
  endtask

  // Offer one query, with random idle cycles ahead of it. Valid stays high
  // from one transaction to the next unless an idle cycle falls between them.
  task automatic offer_query(input answer_t want);
    while (!calm_stretch() && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= want.mode;
    in_value <= want.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_primes.push_back(want);
    offered++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int           p;
    int           m;
    int           i;
    int           pick;
    int           low_bits;
    search_mode_t mode;
    logic [15:0]  value;
    answer_t      want;

    // local sieve: same table the block builds after reset
    for (i = 0; i < TABLE_SIZE; i++) is_prime[i] = 1'b1;
    is_prime[0] = 1'b0;
    is_prime[1] = 1'b0;
    for (p = 2; p * p < TABLE_SIZE; p++) begin
      if (is_prime[p]) begin
        for (m = p * p; m < TABLE_SIZE; m += p) is_prime[m] = 1'b0;
      end
    end

    // Directed rows. Answers are typed in for the trivial bottom of the range,
    // the word edges and the top, where 65521 is the last prime below 2**16.
    add_row(MODE_AT_OR_BELOW, 16'd0,     1'b1, 16'd0,     1'b0);
    add_row(MODE_AT_OR_BELOW, 16'd1,     1'b1, 16'd0,     1'b0);
    add_row(MODE_AT_OR_BELOW, 16'd2,     1'b1, 16'd2,     1'b1);
    add_row(MODE_AT_OR_BELOW, 16'd3,     1'b1, 16'd3,     1'b1);
    add_row(MODE_AT_OR_BELOW, 16'd4,     1'b1, 16'd3,     1'b1);
    add_row(MODE_AT_OR_BELOW, 16'd65535, 1'b1, 16'd65521, 1'b1);
    add_row(MODE_AT_OR_BELOW, 16'd65521, 1'b1, 16'd65521, 1'b1);
    add_row(MODE_AT_OR_ABOVE, 16'd0,     1'b1, 16'd2,     1'b1);
    add_row(MODE_AT_OR_ABOVE, 16'd1,     1'b1, 16'd2,     1'b1);
    add_row(MODE_AT_OR_ABOVE, 16'd2,     1'b1, 16'd2,     1'b1);
    add_row(MODE_AT_OR_ABOVE, 16'd3,     1'b1, 16'd3,     1'b1);
    // nothing prime between here and the top of the output range
    add_row(MODE_AT_OR_ABOVE, 16'd65535, 1'b1, 16'd0,     1'b0);
    add_row(MODE_AT_OR_ABOVE, 16'd65522, 1'b1, 16'd0,     1'b0);
    add_row(MODE_AT_OR_ABOVE, 16'd65521, 1'b1, 16'd65521, 1'b1);
    add_row(MODE_AT_OR_ABOVE, 16'd65520, 1'b1, 16'd65521, 1'b1);
    // edges of the 32-bit store words
    add_row(MODE_AT_OR_BELOW, 16'd31,    1'b1, 16'd31,    1'b1);
    add_row(MODE_AT_OR_ABOVE, 16'd32,    1'b1, 16'd37,    1'b1);
    add_row(MODE_AT_OR_BELOW, 16'd63,    1'b1, 16'd61,    1'b1);
    // widest prime gaps in range make the scan cross into further words
    add_row(MODE_AT_OR_ABOVE, 16'd31398, 1'b0, '0, 1'b0);
    add_row(MODE_AT_OR_BELOW, 16'd31468, 1'b0, '0, 1'b0);
    add_row(MODE_AT_OR_ABOVE, 16'd1328,  1'b0, '0, 1'b0);
    // alternating, single-bit and single-zero patterns
    add_row(MODE_AT_OR_BELOW, 16'h5555,  1'b0, '0, 1'b0);
    add_row(MODE_AT_OR_ABOVE, 16'hAAAA,  1'b0, '0, 1'b0);
    add_row(MODE_AT_OR_BELOW, 16'h8000,  1'b0, '0, 1'b0);
    add_row(MODE_AT_OR_ABOVE, 16'h7FFF,  1'b0, '0, 1'b0);

    // reset released after a hold; the block then fills and sieves on its own
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (query_table[k]) begin
      if (query_table[k].typed) begin
        want.mode  = query_table[k].mode;
        want.value = query_table[k].value;
        want.prime = query_table[k].prime;
        want.found = query_table[k].found;
      end else begin
        want = nearest_prime(query_table[k].mode, query_table[k].value);
      end
      offer_query(want);
    end
    directed_cnt = offered;

    // Random queries: mostly uniform over the range, with extra weight on
    // tiny values, the top of the table and word boundaries.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      mode = search_mode_t'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 10) begin
        value = 16'($urandom_range(40));
      end else if (pick < 20) begin
        value = 16'($urandom_range(65535, 65400));
      end else if (pick < 30) begin
        low_bits = $urandom_range(3);
        low_bits = (low_bits < 2) ? low_bits : 28 + low_bits;
        value = {11'($urandom_range(2047)), 5'(low_bits)};
      end else begin
        value = 16'($urandom_range(65535));
      end
      offer_query(nearest_prime(mode, value));
    end
    in_valid <= 1'b0;

    // drain: the watchdog ends the run if answers stop coming
    while (awaited_primes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d queries (%0d directed, %0d random) in both modes;",
             offered, directed_cnt, offered - directed_cnt);
    $display("%0d answers checked, %0d with no prime in range; one %0d-cycle output stall",
             checked, not_found, HOLD_CYCLES);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready, a calm stretch, and one long hold-off once the
  // sender is well into the random part, so the block backs up its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && offered >= 1200) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (calm_stretch()) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every output transaction against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_primes.size() == 0) begin
        errors++;
        $display("%0t: result with no query pending: prime %0d found %0d",
                 $time, out_prime, out_found);
      end else begin
        head = awaited_primes.pop_front();
        checked++;
        if (!head.found) not_found++;
        if (out_prime !== head.prime) begin
          errors++;
          $display("%0t: prime mismatch (mode %0d value %0d): expected %0d, got %0d",
                   $time, head.mode, head.value, head.prime, out_prime);
        end
        if (out_found !== head.found) begin
          errors++;
          $display("%0t: found mismatch (mode %0d value %0d): expected %0d, got %0d",
                   $time, head.mode, head.value, head.found, out_found);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no transaction on either channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d cycles with no transaction, %0d answers pending",
               $time, quiet_cycles, awaited_primes.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: sim.f
hdl/sps_pkg.sv
hdl/sps_bitram.sv
hdl/sieve_prime_search_top.sv
tb/sv/tb_top.sv
